FILE: rtl/core/pst_pkg.sv
// shared types and constants for the pc speaker tone synthesizer
// divisor table, pit clock reciprocal, register indexes; no dependencies
package pst_pkg;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned MAX_VALID_CODE = 128;
  localparam int unsigned ROM_ENTRIES = 128;

  localparam int unsigned FREQ_W = 17;
  localparam int unsigned VOL_W = 7;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned DIV_W = 13;
  localparam int unsigned PROD_W = FREQ_W + DIV_W;
  localparam int unsigned HALF_W = 9;

  localparam logic [21:0] HALF_PIT_CLOCK = 22'd2386362;
  localparam int unsigned RECIP_SHIFT = 40;
  localparam int unsigned RECIP_W = 19;
  localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(HALF_PIT_CLOCK);
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_FULL[RECIP_W-1:0];

  localparam logic [63:0] MAX_HALF_FULL =
    ((64'd1 << FREQ_W) - 64'd1) * 64'd6818 / 64'(HALF_PIT_CLOCK);
  localparam logic [HALF_W-1:0] MAX_HALF = MAX_HALF_FULL[HALF_W-1:0];

  localparam logic CFG_DEVICE_FREQUENCY = 1'b0;
  localparam logic CFG_VOLUME = 1'b1;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 17'd44100;
  localparam logic [VOL_W-1:0] VOL_RESET = 7'd20;

  localparam logic [DIV_W-1:0] DIVISOR_ROM [ROM_ENTRIES] = '{
    13'd0,    13'd6818, 13'd6628, 13'd6449, 13'd6279, 13'd6087, 13'd5906, 13'd5736,
    13'd5575, 13'd5423, 13'd5279, 13'd5120, 13'd4971, 13'd4830, 13'd4697, 13'd4554,
    13'd4435, 13'd4307, 13'd4186, 13'd4058, 13'd3950, 13'd3836, 13'd3728, 13'd3615,
    13'd3519, 13'd3418, 13'd3323, 13'd3224, 13'd3131, 13'd3043, 13'd2960, 13'd2875,
    13'd2794, 13'd2711, 13'd2633, 13'd2560, 13'd2485, 13'd2415, 13'd2348, 13'd2281,
    13'd2213, 13'd2153, 13'd2089, 13'd2032, 13'd1975, 13'd1918, 13'd1864, 13'd1810,
    13'd1757, 13'd1709, 13'd1659, 13'd1612, 13'd1565, 13'd1521, 13'd1478, 13'd1435,
    13'd1395, 13'd1355, 13'd1316, 13'd1280, 13'd1242, 13'd1207, 13'd1173, 13'd1140,
    13'd1107, 13'd1075, 13'd1045, 13'd1015, 13'd986,  13'd959,  13'd931,  13'd905,
    13'd879,  13'd854,  13'd829,  13'd806,  13'd783,  13'd760,  13'd739,  13'd718,
    13'd697,  13'd677,  13'd658,  13'd640,  13'd621,  13'd604,  13'd586,  13'd570,
    13'd553,  13'd538,  13'd522,  13'd507,  13'd493,  13'd479,  13'd465,  13'd452,
    13'd439,  13'd427,  13'd415,  13'd403,  13'd391,  13'd380,  13'd369,  13'd359,
    13'd348,  13'd339,  13'd329,  13'd319,  13'd310,  13'd302,  13'd293,  13'd285,
    13'd276,  13'd269,  13'd261,  13'd253,  13'd246,  13'd239,  13'd232,  13'd226,
    13'd219,  13'd213,  13'd207,  13'd201,  13'd195,  13'd190,  13'd184,  13'd179
  };

  typedef struct packed {
    logic              valid;
    logic              bad;
    logic              silent;
    logic [HALF_W-1:0] half;
  } pst_half_t;

endpackage

FILE: rtl/core/pst_half_calc.sv
// three-stage pipeline: tone code to half-period length in ticks
// uses pst_pkg for the divisor table and the pit clock reciprocal
module pst_half_calc (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pst_pkg::CODE_W-1:0]   tone_code,
  input  logic [pst_pkg::FREQ_W-1:0]   device_frequency,
  output pst_pkg::pst_half_t           half_out,
  input  logic                         half_ready
);
  import pst_pkg::*;

  localparam int unsigned MUL2_W = PROD_W + RECIP_W;
  localparam int unsigned QD_W = HALF_W + 22;

  logic                v1, v2, v3;
  logic                bad1, bad2, bad3;
  logic                sil1, sil2, sil3;
  logic [PROD_W-1:0]   prod1, prod2;
  logic [HALF_W-1:0]   quot2, half3;
  logic                rdy1, rdy2, rdy3;

  logic                bad_in;
  logic [DIV_W-1:0]    div_in;
  logic [MUL2_W-1:0]   recip_prod;
  logic [QD_W-1:0]     quot_times_d;
  logic [QD_W-1:0]     rem;
  logic [HALF_W-1:0]   half_fix;

  assign rdy3 = !v3 || half_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    bad_in = tone_code > CODE_W'(MAX_VALID_CODE);
    if (tone_code < CODE_W'(ROM_ENTRIES) && 32'(tone_code) < TABLE_DEPTH) begin
      div_in = DIVISOR_ROM[tone_code[6:0]];
    end else begin
      div_in = '0;
    end
  end

  assign recip_prod = MUL2_W'(prod1) * MUL2_W'(RECIP_MULT);
  assign quot_times_d = QD_W'(quot2) * QD_W'(HALF_PIT_CLOCK);
  assign rem = QD_W'(prod2) - quot_times_d;
  assign half_fix = (rem >= QD_W'(HALF_PIT_CLOCK)) ? quot2 + 1'b1 : quot2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      bad1  <= bad_in;
      sil1  <= !bad_in && (div_in == '0);
      prod1 <= PROD_W'(device_frequency) * PROD_W'(div_in);
    end
    if (rdy2 && v1) begin
      bad2  <= bad1;
      sil2  <= sil1;
      prod2 <= prod1;
      quot2 <= recip_prod[RECIP_SHIFT +: HALF_W];
    end
    if (rdy3 && v2) begin
      bad3  <= bad2;
      sil3  <= sil2;
      half3 <= half_fix;
    end
  end

  assign half_out.valid  = v3;
  assign half_out.bad    = bad3;
  assign half_out.silent = sil3;
  assign half_out.half   = half3;

  a_half_range: assert property (@(posedge clk) disable iff (rst)
    v3 && !bad3 && !sil3 |-> half3 <= MAX_HALF)
    else $error("half-period above table maximum");

  a_bad_not_silent: assert property (@(posedge clk) disable iff (rst)
    v3 |-> !(bad3 && sil3))
    else $error("code flagged both bad and silent");

  a_quot_close: assert property (@(posedge clk) disable iff (rst)
    v2 |-> quot2 <= MAX_HALF)
    else $error("reciprocal estimate out of range");

endmodule

FILE: rtl/core/pc_speaker_tone_synth_core.sv
// pc speaker square-wave tone synthesizer, top level
// uses pst_pkg and pst_half_calc (half-period pipeline)
//
// usage:
//   input channel in_valid/in_ready carries one tone_code per sample tick.
//   output channel out_valid/out_ready returns one transaction per input:
//   sample (+volume, -volume or zero) and bad_tone for codes above 128.
//   config channel cfg_valid/cfg_ready writes device_frequency (index 0)
//   or volume (index 1) from cfg_data; always ready, write only when idle.
// timing:
//   one item per cycle sustained while out_ready stays high. three stages
//   compute the half-period (table and frequency multiply, reciprocal
//   multiply, remainder correction), the fourth updates polarity and
//   phase counter and holds the result.
// reset:
//   synchronous rst empties the pipeline, restores 44100 hz and volume 20,
//   sets negative polarity and clears the phase counter.
// stall:
//   each stage holds while the one after it is full and holding, so a
//   stalled receiver fills the bubbles first and then drops in_ready.
module pc_speaker_tone_synth_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pst_pkg::CODE_W-1:0]          tone_code,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pst_pkg::SAMPLE_W-1:0] sample,
  output logic                                bad_tone,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [pst_pkg::FREQ_W-1:0]          cfg_data
);
  import pst_pkg::*;

  logic [FREQ_W-1:0]   device_frequency;
  logic [VOL_W-1:0]    volume;
  logic                polarity, polarity_next;
  logic [HALF_W-1:0]   phase_count, phase_count_next;
  pst_half_t           half_s;
  logic                half_ready;
  logic                fire;
  logic [SAMPLE_W-1:0] amp;

  assign cfg_ready = 1'b1;

  pst_half_calc u_half (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .tone_code        (tone_code),
    .device_frequency (device_frequency),
    .half_out         (half_s),
    .half_ready       (half_ready)
  );

  assign half_ready = !out_valid || out_ready;
  assign fire = half_s.valid && half_ready;

  always_comb begin
    polarity_next    = polarity;
    phase_count_next = phase_count;
    amp = polarity ? SAMPLE_W'(-{1'b0, volume}) : SAMPLE_W'({1'b0, volume});
    if (half_s.bad) begin
      amp = '0;
    end else if (half_s.silent) begin
      amp = '0;
      phase_count_next = '0;
    end else if (phase_count >= half_s.half) begin
      polarity_next    = !polarity;
      phase_count_next = '0;
    end else begin
      phase_count_next = phase_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_frequency <= FREQ_RESET;
      volume           <= VOL_RESET;
      polarity         <= 1'b1;
      phase_count      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEVICE_FREQUENCY: device_frequency <= cfg_data;
          CFG_VOLUME:           volume <= cfg_data[VOL_W-1:0];
          default:              ;
        endcase
      end
      if (fire) begin
        polarity    <= polarity_next;
        phase_count <= phase_count_next;
      end
      if (half_ready) out_valid <= half_s.valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      sample   <= amp;
      bad_tone <= half_s.bad;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_tone |-> sample == '0)
    else $error("bad tone with nonzero sample");

  a_bad_keeps_state: assert property (@(posedge clk) disable iff (rst)
    fire && half_s.bad |=> $stable(polarity) && $stable(phase_count))
    else $error("bad tone changed state");

  a_silence_clears: assert property (@(posedge clk) disable iff (rst)
    fire && half_s.silent |=> phase_count == '0 && $stable(polarity))
    else $error("silence did not clear phase counter");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase_count <= MAX_HALF)
    else $error("phase counter beyond largest half-period");

endmodule

FILE: test/testbench.sv
// testbench for pc_speaker_tone_synth_core: directed and random tone codes under several
// sample rate and volume settings, checked against an in-bench square-wave predictor
// depends on pst_pkg for port widths and register indexes
module testbench;

  localparam int unsigned CODE_W = pst_pkg::CODE_W;
  localparam int unsigned SAMPLE_W = pst_pkg::SAMPLE_W;
  localparam int unsigned FREQ_W = pst_pkg::FREQ_W;
  localparam logic [63:0] PIT_CLOCK_X2 = 64'd2386362;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic [12:0] PIT_DIVISORS [128] = '{
    13'd0,    13'd6818, 13'd6628, 13'd6449, 13'd6279, 13'd6087, 13'd5906, 13'd5736,
    13'd5575, 13'd5423, 13'd5279, 13'd5120, 13'd4971, 13'd4830, 13'd4697, 13'd4554,
    13'd4435, 13'd4307, 13'd4186, 13'd4058, 13'd3950, 13'd3836, 13'd3728, 13'd3615,
    13'd3519, 13'd3418, 13'd3323, 13'd3224, 13'd3131, 13'd3043, 13'd2960, 13'd2875,
    13'd2794, 13'd2711, 13'd2633, 13'd2560, 13'd2485, 13'd2415, 13'd2348, 13'd2281,
    13'd2213, 13'd2153, 13'd2089, 13'd2032, 13'd1975, 13'd1918, 13'd1864, 13'd1810,
    13'd1757, 13'd1709, 13'd1659, 13'd1612, 13'd1565, 13'd1521, 13'd1478, 13'd1435,
    13'd1395, 13'd1355, 13'd1316, 13'd1280, 13'd1242, 13'd1207, 13'd1173, 13'd1140,
    13'd1107, 13'd1075, 13'd1045, 13'd1015, 13'd986,  13'd959,  13'd931,  13'd905,
    13'd879,  13'd854,  13'd829,  13'd806,  13'd783,  13'd760,  13'd739,  13'd718,
    13'd697,  13'd677,  13'd658,  13'd640,  13'd621,  13'd604,  13'd586,  13'd570,
    13'd553,  13'd538,  13'd522,  13'd507,  13'd493,  13'd479,  13'd465,  13'd452,
    13'd439,  13'd427,  13'd415,  13'd403,  13'd391,  13'd380,  13'd369,  13'd359,
    13'd348,  13'd339,  13'd329,  13'd319,  13'd310,  13'd302,  13'd293,  13'd285,
    13'd276,  13'd269,  13'd261,  13'd253,  13'd246,  13'd239,  13'd232,  13'd226,
    13'd219,  13'd213,  13'd207,  13'd201,  13'd195,  13'd190,  13'd184,  13'd179
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                bad;
  } tone_out_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CODE_W-1:0]          tone_code = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       bad_tone;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = pst_pkg::CFG_DEVICE_FREQUENCY;
  logic [FREQ_W-1:0]          cfg_data = '0;

  logic [CODE_W-1:0] pending_codes [$];
  tone_out_t         expected_samples [$];

  logic [FREQ_W-1:0] rate_hz = 17'd44100;
  logic [6:0]        amplitude = 7'd20;
  logic              tone_negative = 1'b1;
  logic [8:0]        phase_ticks = '0;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  pc_speaker_tone_synth_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .tone_code(tone_code),
    .out_valid(out_valid), .out_ready(out_ready), .sample(sample), .bad_tone(bad_tone),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic tone_out_t next_tone_sample(input logic [CODE_W-1:0] code);
    tone_out_t   r;
    logic [12:0] divisor;
    logic [63:0] half_period;
    r.sample = '0;
    r.bad = 1'b0;
    divisor = '0;
    if (code > 8'd128) begin
      r.bad = 1'b1;
      return r;
    end
    if (code < 8'd128) divisor = PIT_DIVISORS[code[6:0]];
    if (divisor == '0) begin
      phase_ticks = '0;
      return r;
    end
    half_period = (64'(rate_hz) * 64'(divisor)) / PIT_CLOCK_X2;
    r.sample = tone_negative ? 8'(-int'(amplitude)) : 8'(amplitude);
    if (64'(phase_ticks) >= half_period) begin
      tone_negative = ~tone_negative;
      phase_ticks = '0;
    end else begin
      phase_ticks = phase_ticks + 9'd1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // driver: predicts each transaction as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_samples.push_back(next_tone_sample(tone_code));
      if (!in_valid || in_ready) begin
        if (pending_codes.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          tone_code <= pending_codes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tone_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction sample %0d", sample));
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want.sample)
            report_mismatch($sformatf("sample %0d, want %0d", sample,
                                      $signed(want.sample)));
          if (bad_tone !== want.bad)
            report_mismatch($sformatf("bad_tone %b, want %b", bad_tone, want.bad));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("pc_speaker_tone_synth_core verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [FREQ_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pst_pkg::CFG_DEVICE_FREQUENCY) rate_hz = data;
    else amplitude = data[6:0];
  endtask

  task automatic push_codes(input logic [CODE_W-1:0] code, input int count);
    repeat (count) pending_codes.push_back(code);
  endtask

  // runs of one tone with occasional silence, table end, invalid codes and noise
  task automatic add_random_items(input int total);
    int                added;
    int                run_len;
    int unsigned       pick;
    logic [CODE_W-1:0] code;
    added = 0;
    while (added < total) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        pending_codes.push_back(CODE_W'($urandom_range(255)));
        added++;
      end else begin
        if (pick < 20) code = 8'd0;
        else if (pick < 24) code = 8'd128;
        else code = CODE_W'($urandom_range(127, 1));
        if ($urandom_range(7) == 0) run_len = $urandom_range(400, 1);
        else run_len = $urandom_range(40, 1);
        repeat (run_len) begin
          if ($urandom_range(99) < 3) pending_codes.push_back(CODE_W'($urandom_range(255, 129)));
          else pending_codes.push_back(code);
        end
        added += run_len;
      end
    end
  endtask

  task automatic drain;
    while (pending_codes.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 26;
    recv_idle = 64;
    // reset settings: invalid codes, table end, short tone, then a tone change
    // while the counter is already past the new half-period
    pending_codes.push_back(8'd0);
    pending_codes.push_back(8'd255);
    pending_codes.push_back(8'd129);
    pending_codes.push_back(8'd128);
    pending_codes.push_back(8'd170);
    pending_codes.push_back(8'd85);
    push_codes(8'd127, 5);
    push_codes(8'd1, 6);
    push_codes(8'd127, 2);
    pending_codes.push_back(8'd0);
    pending_codes.push_back(8'd64);
    pending_codes.push_back(8'd2);
    add_random_items(330);
    drain();

    // zero rate: flips on every sounding tick
    write_reg(pst_pkg::CFG_DEVICE_FREQUENCY, 17'd0);
    write_reg(pst_pkg::CFG_VOLUME, 17'd127);
    push_codes(8'd1, 3);
    pending_codes.push_back(8'd200);
    push_codes(8'd1, 2);
    add_random_items(320);
    drain();

    send_idle = 64;
    recv_idle = 26;
    write_reg(pst_pkg::CFG_DEVICE_FREQUENCY, 17'h1FFFF);
    write_reg(pst_pkg::CFG_VOLUME, 17'h1FF80);
    add_random_items(330);
    drain();

    write_reg(pst_pkg::CFG_DEVICE_FREQUENCY, 17'd4000);
    write_reg(pst_pkg::CFG_VOLUME, 17'd1);
    add_random_items(330);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_reg(pst_pkg::CFG_DEVICE_FREQUENCY, 17'd96000);
    write_reg(pst_pkg::CFG_VOLUME, {10'($urandom_range(1023)), 7'($urandom_range(127))});
    add_random_items(330);
    drain();

    write_reg(pst_pkg::CFG_DEVICE_FREQUENCY, FREQ_W'($urandom_range(131071)));
    write_reg(pst_pkg::CFG_VOLUME, FREQ_W'($urandom_range(131071)));
    add_random_items(330);
    drain();

    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("pc_speaker_tone_synth_core verification clean");
    end else begin
      $display("pc_speaker_tone_synth_core verification failed");
    end
    $finish;
  end

endmodule
